// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the button click classifier RTL.
// Needs no other file; bcc_step includes it to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on the rising edge of clk_i, off while rst_ni is low.
`define BCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bcc assertion failed");
// Check a property on a named clock and active-low reset.
`define BCC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bcc assertion failed");
`else
`define BCC_ASSERT(lbl, prop)
`define BCC_ASSERT_CLK(lbl, clk, rstn, prop)
`endif
`endif

// ----- hw/rtl/bcc_pkg.sv -----
// Types, codes and reset constants of the button click classifier.
// Used by bcc_cfg_regs, bcc_step and button_click_classifier; depends on nothing.
package bcc_pkg;

  // Default width of the hold counter.
  localparam int unsigned HoldCountBitsDef = 10;

  // Machine phase codes.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;

  // Bit positions of the pending event flags.
  localparam int unsigned EvSingleBit = 0;
  localparam int unsigned EvDoubleBit = 1;
  localparam int unsigned EvLongBit   = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CLICK_GAP  = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [2:0] CFG_EN_SINGLE  = 3'd2;
  localparam logic [2:0] CFG_EN_DOUBLE  = 3'd3;
  localparam logic [2:0] CFG_EN_LONG    = 3'd4;

  // Register reset values.
  localparam logic [7:0] ClickGapReset  = 8'd20;
  localparam logic [9:0] LongPressReset = 10'd80;

  // One input item: sampled level and acknowledge mask.
  typedef struct packed {
    logic       key_down;
    logic [2:0] ack_mask;
  } in_item_t;

  // One result item: pending flags and phase after the tick.
  typedef struct packed {
    logic       single_pending;
    logic       double_pending;
    logic       long_pending;
    logic [1:0] key_phase;
  } out_item_t;

  // Current configuration as seen by the update logic.
  typedef struct packed {
    logic [7:0] click_gap_ticks;
    logic [9:0] long_press_ticks;
    logic       enable_single;
    logic       enable_double;
    logic       enable_long;
  } cfg_t;

endpackage

// ----- hw/rtl/button_click_classifier.sv -----
// Top level of the button click classifier: input register, update, result register.
// Depends on bcc_pkg, bcc_cfg_regs and bcc_step.
//
//   channel  | valid / ready            | payload
//   ---------+--------------------------+-----------------------------
//   in       | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//   out      | out_valid_o / out_ready_i| out_item_o (out_item_t)
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An item passes through the input register and then the result register;
// one item is taken every cycle while the output is not stalled.
// The state update happens as an item moves from the input register to the
// result register, so a stalled output holds the state with it.
// Reset clears the valid bits and puts the machine in idle, locked.
// Configuration writes are always taken.
module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int unsigned HOLD_COUNT_BITS = HoldCountBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      step;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register can take a new item when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  bcc_step #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/bcc_cfg_regs.sv -----
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for the register indexes, reset values and cfg_t.
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_gap_ticks  <= ClickGapReset;
      cfg_q.long_press_ticks <= LongPressReset;
      cfg_q.enable_single    <= 1'b1;
      cfg_q.enable_double    <= 1'b0;
      cfg_q.enable_long      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLICK_GAP:  cfg_q.click_gap_ticks  <= cfg_data_i[7:0];
        CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        CFG_EN_SINGLE:  cfg_q.enable_single    <= cfg_data_i[0];
        CFG_EN_DOUBLE:  cfg_q.enable_double    <= cfg_data_i[0];
        CFG_EN_LONG:    cfg_q.enable_long      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/bcc_step.sv -----
// Click classifier state and its one-tick update logic.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcc_step
  import bcc_pkg::*;
#(
  parameter int unsigned HOLD_COUNT_BITS = HoldCountBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  // Compare width for the hold counter against the long press threshold.
  localparam int unsigned CmpW = (HOLD_COUNT_BITS > 10) ? HOLD_COUNT_BITS : 10;

  logic [1:0]                 phase_q, phase_d;
  logic [8:0]                 gap_q, gap_d;
  logic [HOLD_COUNT_BITS-1:0] hold_q, hold_d;
  logic                       lock_q, lock_d;
  logic [2:0]                 pend_q, pend_d;

  logic [8:0]                 gap_limit;
  logic [8:0]                 gap_inc;
  logic [8:0]                 gap_full;
  logic [HOLD_COUNT_BITS-1:0] hold_inc;

  // Shared terms: saturating gap count, the gap value that ends a window and the saturating hold count.
  always_comb begin
    gap_limit = {1'b0, cfg_i.click_gap_ticks};
    gap_full  = gap_limit + 9'd1;
    gap_inc   = (gap_q <= gap_limit) ? gap_q + 9'd1 : gap_q;
    hold_inc  = (&hold_q) ? hold_q : hold_q + HOLD_COUNT_BITS'(1);
  end

  // Next state for one tick; acknowledges are applied first.
  always_comb begin
    phase_d = phase_q;
    gap_d   = gap_q;
    hold_d  = hold_q;
    lock_d  = lock_q;
    pend_d  = pend_q & ~item_i.ack_mask;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.key_down) begin
          phase_d = PH_DEBOUNCE;
        end
        gap_d = gap_inc;
        // A lone click is reported once the gap window has run out.
        if (!lock_q && (gap_inc > gap_limit)) begin
          pend_d[EvSingleBit] = 1'b1;
          lock_d              = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        if (item_i.key_down) begin
          phase_d = PH_HELD;
          lock_d  = 1'b0;
        end else begin
          phase_d = PH_IDLE;
        end
        gap_d = gap_inc;
      end
      PH_HELD: begin
        if (!item_i.key_down) begin
          // Release: classify the click unless already reported.
          phase_d = PH_IDLE;
          hold_d  = '0;
          if (!lock_q) begin
            if (cfg_i.enable_double && (gap_q <= gap_limit)) begin
              pend_d[EvDoubleBit] = 1'b1;
              gap_d               = gap_full;
              lock_d              = 1'b1;
            end else if (cfg_i.enable_single && !cfg_i.enable_double) begin
              pend_d[EvSingleBit] = 1'b1;
              lock_d              = 1'b1;
            end else begin
              gap_d = '0;
            end
          end
        end else if (!lock_q && cfg_i.enable_long) begin
          // Still held: count toward a long press.
          hold_d = hold_inc;
          if (CmpW'(hold_inc) >= CmpW'(cfg_i.long_press_ticks)) begin
            pend_d[EvLongBit] = 1'b1;
            gap_d             = gap_full;
            lock_d            = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers advance once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      gap_q   <= '0;
      hold_q  <= '0;
      lock_q  <= 1'b1;
      pend_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      gap_q   <= gap_d;
      hold_q  <= hold_d;
      lock_q  <= lock_d;
      pend_q  <= pend_d;
    end
  end

  // The result is the state after this tick.
  assign result_o.single_pending = pend_d[EvSingleBit];
  assign result_o.double_pending = pend_d[EvDoubleBit];
  assign result_o.long_pending   = pend_d[EvLongBit];
  assign result_o.key_phase      = phase_d;

  // The lock only opens on entering the held phase.
  `BCC_ASSERT(a_unlock_in_held, $fell(lock_q) |-> (phase_q == PH_HELD))
  // The hold counter is clear outside the held phase.
  `BCC_ASSERT(a_hold_only_held, (hold_q != '0) |-> (phase_q == PH_HELD))
  // Pending flags only change on a tick.
  `BCC_ASSERT(a_pend_on_step, !step_i |=> $stable(pend_q))

endmodule
